// File: hw/rtl/tcpq_pkg.sv
// Shared constants, codes and controller/datapath bus types for the two-class priority queue.
`default_nettype none

package tcpq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 16;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    localparam logic signed [DATA_W-1:0] THR_RESET = 16'sd60;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PRIO   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef enum logic {RA_PTR, RA_PTR_M1} t_raddr_sel;
    typedef enum logic [1:0] {WA_PTR, WA_PTR_M1, WA_POS} t_waddr_sel;
    typedef enum logic {WD_RDATA, WD_VALUE} t_wdata_sel;
    typedef enum logic {POS_PTR, POS_COUNT} t_pos_sel;

    typedef struct packed {
        logic              cap_in;
        logic              ptr_clr;
        logic              ptr_inc;
        logic              ptr_dec;
        logic              shift_ld;
        t_pos_sel          pos_sel;
        logic              rd_en;
        t_raddr_sel        raddr_sel;
        logic              wr_en;
        t_waddr_sel        waddr_sel;
        t_wdata_sel        wdata_sel;
        logic              cnt_inc;
        logic              cnt_dec;
        logic              stat_ld;
        logic [STAT_W-1:0] stat_code;
        logic              rm_cap;
        logic              out_ld;
    } t_cmd_bus;

    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic in_hi;
        logic rd_hi;
        logic ptr_eq_count;
        logic ptr_eq_pos;
    } t_stat_bus;

endpackage

`default_nettype wire

// File: hw/rtl/tcpq_dpath.sv
// Datapath: entry store, count, threshold, scan/shift pointers and result register.
`default_nettype none

module tcpq_dpath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [tcpq_pkg::DATA_W-1:0]  i_cfg_wdata,
    input  wire logic [tcpq_pkg::DATA_W-1:0]  i_in_value,
    input  wire tcpq_pkg::t_cmd_bus           i_cmd,
    output tcpq_pkg::t_stat_bus               o_stat,
    output logic [tcpq_pkg::STAT_W-1:0]       o_status,
    output logic [tcpq_pkg::DATA_W-1:0]       o_removed_value,
    output logic [tcpq_pkg::OCC_W-1:0]        o_occupancy
);
    import tcpq_pkg::*;

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rdata;
    logic signed [DATA_W-1:0] r_thr;
    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] r_removed;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         r_ptr;
    logic [IDX_W-1:0]         r_pos;
    logic [STAT_W-1:0]        r_status;
    logic [STAT_W-1:0]        r_out_status;
    logic [DATA_W-1:0]        r_out_removed;
    logic [OCC_W-1:0]         r_out_occ;

    logic [CNT_W-1:0]         ptr_m1;
    logic [IDX_W-1:0]         raddr;
    logic [IDX_W-1:0]         waddr;
    logic signed [DATA_W-1:0] wdata;

    assign ptr_m1   = r_ptr - CNT_W'(1);

    always_comb begin
        case (i_cmd.raddr_sel)
            RA_PTR:    raddr = r_ptr[IDX_W-1:0];
            RA_PTR_M1: raddr = ptr_m1[IDX_W-1:0];
            default:   raddr = r_ptr[IDX_W-1:0];
        endcase
        case (i_cmd.waddr_sel)
            WA_PTR:    waddr = r_ptr[IDX_W-1:0];
            WA_PTR_M1: waddr = ptr_m1[IDX_W-1:0];
            WA_POS:    waddr = r_pos;
            default:   waddr = r_pos;
        endcase
        case (i_cmd.wdata_sel)
            WD_RDATA: wdata = r_rdata;
            WD_VALUE: wdata = r_value;
            default:  wdata = r_value;
        endcase
    end

    // entry store: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[waddr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_thr   <= THR_RESET;
        end else begin
            if (i_cfg_we) begin
                r_thr <= $signed(i_cfg_wdata);
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_value   <= $signed(i_in_value);
            r_removed <= '0;
        end else if (i_cmd.rm_cap) begin
            r_removed <= r_rdata;
        end
        if (i_cmd.stat_ld) begin
            r_status <= i_cmd.stat_code;
        end
        if (i_cmd.ptr_clr) begin
            r_ptr <= '0;
        end else if (i_cmd.shift_ld) begin
            r_ptr <= r_count;
        end else if (i_cmd.ptr_inc) begin
            r_ptr <= r_ptr + CNT_W'(1);
        end else if (i_cmd.ptr_dec) begin
            r_ptr <= ptr_m1;
        end
        // only taken while not full, so both fit the index width
        if (i_cmd.shift_ld) begin
            r_pos <= (i_cmd.pos_sel == POS_PTR) ? r_ptr[IDX_W-1:0] : r_count[IDX_W-1:0];
        end
        if (i_cmd.out_ld) begin
            r_out_status  <= r_status;
            r_out_removed <= r_removed;
            r_out_occ     <= OCC_W'(r_count);
        end
    end

    always_comb begin
        o_stat.count_zero   = (r_count == '0);
        o_stat.count_full   = (r_count == CNT_W'(DEPTH));
        o_stat.in_hi        = ($signed(i_in_value) >= r_thr);
        o_stat.rd_hi        = (r_rdata >= r_thr);
        o_stat.ptr_eq_count = (r_ptr == r_count);
        o_stat.ptr_eq_pos   = (r_ptr == CNT_W'(r_pos));
    end

    assign o_status        = r_out_status;
    assign o_removed_value = r_out_removed;
    assign o_occupancy     = r_out_occ;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");
    a_inc_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_inc |-> (r_count != CNT_W'(DEPTH)))
        else $error("insert committed into a full store");
    a_dec_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_dec |-> (r_count != '0))
        else $error("remove committed on an empty store");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/tcpq_ctrl.sv
// Controller: sequences scan, shift and remove passes over the entry store.
`default_nettype none

module tcpq_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_tvalid,
    input  wire logic [tcpq_pkg::CMD_W-1:0]  i_s_cmd,
    output logic                             o_s_tready,
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    input  wire tcpq_pkg::t_stat_bus         i_stat,
    output tcpq_pkg::t_cmd_bus               o_cmd
);
    import tcpq_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN_RD, ST_SCAN_CHK, ST_SHIFT_RD, ST_SHIFT_WR,
        ST_RM_RD, ST_RM_CAP, ST_MV_RD, ST_MV_WR, ST_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;
    logic   accept;

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_m_valid;

    always_comb begin
        o_cmd     = '0;
        n_state   = r_state;
        n_m_valid = r_m_valid && !i_m_tready;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.cap_in    = 1'b1;
                    o_cmd.stat_ld   = 1'b1;
                    o_cmd.stat_code = STAT_OK;
                    case (i_s_cmd)
                        CMD_APPEND, CMD_PRIO: begin
                            if (i_stat.count_full) begin
                                o_cmd.stat_code = STAT_FULL;
                                n_state         = ST_DONE;
                            end else if (i_s_cmd == CMD_PRIO && !i_stat.count_zero
                                         && i_stat.in_hi) begin
                                o_cmd.ptr_clr = 1'b1;
                                n_state       = ST_SCAN_RD;
                            end else begin
                                o_cmd.shift_ld = 1'b1;
                                o_cmd.pos_sel  = POS_COUNT;
                                n_state        = ST_SHIFT_RD;
                            end
                        end
                        CMD_REMOVE: begin
                            if (i_stat.count_zero) begin
                                o_cmd.stat_code = STAT_EMPTY;
                                n_state         = ST_DONE;
                            end else begin
                                o_cmd.ptr_clr = 1'b1;
                                n_state       = ST_RM_RD;
                            end
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_SCAN_RD: begin
                if (i_stat.ptr_eq_count) begin
                    // whole queue is priority: insert at tail
                    o_cmd.shift_ld = 1'b1;
                    o_cmd.pos_sel  = POS_PTR;
                    n_state        = ST_SHIFT_RD;
                end else begin
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.raddr_sel = RA_PTR;
                    n_state         = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK: begin
                if (i_stat.rd_hi) begin
                    o_cmd.ptr_inc = 1'b1;
                    n_state       = ST_SCAN_RD;
                end else begin
                    o_cmd.shift_ld = 1'b1;
                    o_cmd.pos_sel  = POS_PTR;
                    n_state        = ST_SHIFT_RD;
                end
            end
            ST_SHIFT_RD: begin
                if (i_stat.ptr_eq_pos) begin
                    o_cmd.wr_en     = 1'b1;
                    o_cmd.waddr_sel = WA_POS;
                    o_cmd.wdata_sel = WD_VALUE;
                    o_cmd.cnt_inc   = 1'b1;
                    n_state         = ST_DONE;
                end else begin
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.raddr_sel = RA_PTR_M1;
                    n_state         = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR: begin
                o_cmd.wr_en     = 1'b1;
                o_cmd.waddr_sel = WA_PTR;
                o_cmd.wdata_sel = WD_RDATA;
                o_cmd.ptr_dec   = 1'b1;
                n_state         = ST_SHIFT_RD;
            end
            ST_RM_RD: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.raddr_sel = RA_PTR;
                n_state         = ST_RM_CAP;
            end
            ST_RM_CAP: begin
                o_cmd.rm_cap  = 1'b1;
                o_cmd.ptr_inc = 1'b1;
                n_state       = ST_MV_RD;
            end
            ST_MV_RD: begin
                if (i_stat.ptr_eq_count) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = ST_DONE;
                end else begin
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.raddr_sel = RA_PTR;
                    n_state         = ST_MV_WR;
                end
            end
            ST_MV_WR: begin
                o_cmd.wr_en     = 1'b1;
                o_cmd.waddr_sel = WA_PTR_M1;
                o_cmd.wdata_sel = WD_RDATA;
                o_cmd.ptr_inc   = 1'b1;
                n_state         = ST_MV_RD;
            end
            ST_DONE: begin
                // wait for the output register to free up
                if (!r_m_valid || i_m_tready) begin
                    o_cmd.out_ld = 1'b1;
                    n_m_valid    = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

`ifndef ASSERT_OFF
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != ST_IDLE))
        else $error("request accepted but controller stayed idle");
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_ld |-> (!r_m_valid || i_m_tready))
        else $error("result register overwritten while still held");
    a_taken_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && i_m_tready && !o_cmd.out_ld) |=> !r_m_valid)
        else $error("result still valid after being taken");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/two_class_priority_queue.sv
// Top level of the two-class priority queue: controller and datapath joined, stream ports packed.
//
//  channel   dir  handshake                  tdata                       tuser
//  s (cmd)   in   i_s_tvalid / o_s_tready    [15:0] value                [1:0] cmd
//  m (res)   out  o_m_tvalid / i_m_tready    [15:0] removed, [20:16] occ [1:0] status
//  cfg       in   i_cfg_we                   i_cfg_wdata = threshold     -
//
//  A request is taken only when the controller is idle; one result per request.
//  Append and low insert write at the tail; priority insert scans past the leading entries at or
//  above the threshold, then shifts the rest up one slot, from the tail down; remove reads the head
//  and moves each later entry down one slot. Full, empty and unused commands leave the store alone.
//  A held result does not block the next request; only the final load waits on i_m_tready.
//  Reset clears the count and loads threshold 60; no clearing pass over the store.
`default_nettype none

module two_class_priority_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [15:0] value
    input  wire logic [1:0]  i_s_tuser,   // [1:0] cmd
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // [15:0] removed_value, [20:16] occupancy, rest zero
    output logic [1:0]       o_m_tuser    // [1:0] status
);
    import tcpq_pkg::*;

    t_cmd_bus          cmd_bus;
    t_stat_bus         stat_bus;
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] removed_value;
    logic [OCC_W-1:0]  occupancy;

    tcpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_cmd    (i_s_tuser),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat_bus),
        .o_cmd      (cmd_bus)
    );

    tcpq_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_value      (i_s_tdata),
        .i_cmd           (cmd_bus),
        .o_stat          (stat_bus),
        .o_status        (status),
        .o_removed_value (removed_value),
        .o_occupancy     (occupancy)
    );

    assign o_m_tdata = {3'b000, occupancy, removed_value};
    assign o_m_tuser = status;

endmodule

`default_nettype wire

// File: tb/sv/queue_order_checker.sv
// Checker for the two-class priority queue: tracks the queue, predicts each result, compares.
module queue_order_checker
    import tcpq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,    // [15:0] value
    input  logic [1:0]  i_s_tuser,    // [1:0] cmd
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,    // [15:0] removed_value, [20:16] occupancy
    input  logic [1:0]  i_m_tuser,    // [1:0] status
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] removed;
        logic [OCC_W-1:0]         occ;
    } t_outcome;

    logic signed [DATA_W-1:0] slots [DEPTH];
    int                       fill;
    logic signed [DATA_W-1:0] threshold;
    t_outcome                 awaited_outcomes[$];
    int                       fails = 0;

    // Applies one request to the tracked queue and returns the result it must give.
    function automatic t_outcome apply_request(input logic [CMD_W-1:0] cmd,
                                               input logic signed [DATA_W-1:0] val);
        t_outcome res;
        int       slot;
        res = '0;
        case (cmd)
            CMD_APPEND, CMD_PRIO: begin
                if (fill >= DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    slot = fill;
                    // high priority value goes behind the leading run of high entries
                    if (cmd == CMD_PRIO && fill > 0 && val >= threshold) begin
                        slot = 0;
                        while (slot < fill && slots[slot] >= threshold)
                            slot++;
                    end
                    for (int i = fill; i > slot; i--)
                        slots[i] = slots[i-1];
                    slots[slot] = val;
                    fill++;
                end
            end
            CMD_REMOVE: begin
                if (fill == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    res.removed = slots[0];
                    for (int i = 1; i < fill; i++)
                        slots[i-1] = slots[i];
                    fill--;
                end
            end
            default: ;
        endcase
        res.occ = OCC_W'(fill);
        return res;
    endfunction

    task automatic compare_field(input string name, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            fill = 0;
            threshold = THR_RESET;
            awaited_outcomes.delete();
        end else begin
            if (i_cfg_we)
                threshold = i_cfg_wdata;
            if (i_m_tvalid && i_m_tready) begin
                if (awaited_outcomes.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none, got status %0d removed %0d occupancy %0d",
                             $time, i_m_tuser, $signed(i_m_tdata[15:0]), i_m_tdata[20:16]);
                end else begin
                    want = awaited_outcomes.pop_front();
                    compare_field("status", {30'd0, want.status}, {30'd0, i_m_tuser});
                    compare_field("removed_value", want.removed, $signed(i_m_tdata[15:0]));
                    compare_field("occupancy", {27'd0, want.occ}, {27'd0, i_m_tdata[20:16]});
                end
            end
            if (i_s_tvalid && i_s_tready)
                awaited_outcomes.push_back(apply_request(i_s_tuser, i_s_tdata));
        end
        o_fail_count <= fails;
        o_pending    <= awaited_outcomes.size();
    end

endmodule

// File: tb/sv/testbench.sv
// Top of the two-class priority queue testbench: clock, reset, request stimulus and verdict.
module testbench;
    import tcpq_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS   = 270;
    localparam int HOLD_CYCLES   = 300;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    logic        calm = 1'b0;
    logic        hold_armed = 1'b0;
    logic        hold_spent = 1'b0;
    logic signed [15:0] cur_threshold = THR_RESET;

    two_class_priority_queue u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser)
    );

    queue_order_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off so the queue backs up
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_armed && !hold_spent) begin
                hold_spent = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 7);
            end
        end
    end

    task automatic push_request(input logic [CMD_W-1:0] cmd, input logic [15:0] val);
        while (!calm && $urandom_range(0, 99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= val;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop offering requests and wait until every result is back and the block is quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [15:0] val);
        settle();
        cfg_we        <= 1'b1;
        cfg_wdata     <= val;
        cur_threshold  = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Many values around the threshold, some extremes, the rest anywhere
    function automatic logic [15:0] pick_value(input logic signed [15:0] thr);
        int near;
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            near = int'(thr) + int'($urandom_range(0, 4)) - 2;
            if (near > 32767)
                near = 32767;
            if (near < -32768)
                near = -32768;
            return 16'(near);
        end
        if (r < 50) begin
            case ($urandom_range(0, 3))
                0: return 16'h7FFF;
                1: return 16'h8000;
                2: return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        return 16'($urandom);
    endfunction

    initial begin
        logic [15:0]      phase_thr [6];
        int               remove_pct;
        int               r;
        logic [CMD_W-1:0] cmd;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_APPEND;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, threshold at its reset value
        push_request(CMD_REMOVE, 16'h0000);      // remove on empty
        push_request(CMD_UNUSED, 16'h1234);
        push_request(CMD_PRIO,   16'h7FFF);      // high insert into empty goes to tail
        push_request(CMD_APPEND, 16'h8000);
        push_request(CMD_PRIO,   16'd60);        // exactly at threshold: behind the high run
        push_request(CMD_PRIO,   16'd59);        // just below: tail
        push_request(CMD_APPEND, 16'h0000);
        push_request(CMD_PRIO,   16'h7FFF);
        push_request(CMD_APPEND, 16'h5555);
        push_request(CMD_PRIO,   16'hAAAA);
        for (int k = 0; k < 8; k++)
            push_request(k[0] ? CMD_PRIO : CMD_APPEND, 16'(56 + k));
        push_request(CMD_APPEND, 16'h00FF);      // full
        push_request(CMD_PRIO,   16'h7FFF);      // full
        push_request(CMD_UNUSED, 16'hFFFF);
        repeat (4) push_request(CMD_REMOVE, 16'hFFFF);

        phase_thr[0] = THR_RESET;
        phase_thr[1] = 16'h8000;
        phase_thr[2] = 16'h7FFF;
        phase_thr[3] = 16'h0000;
        phase_thr[4] = 16'($urandom);
        phase_thr[5] = 16'd60;

        for (int p = 0; p < 6; p++) begin
            if (p > 0)
                write_threshold(phase_thr[p]);
            remove_pct = 48;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // bursts that fill, drain or churn the queue
                if (k % 45 == 0) begin
                    case ($urandom_range(0, 2))
                        0: remove_pct = 25;
                        1: remove_pct = 72;
                        default: remove_pct = 48;
                    endcase
                end
                calm = (p == 2 && k < 120);
                if (p == 3 && k == 0)
                    hold_armed = 1'b1;
                r = $urandom_range(0, 99);
                if (r < 2)
                    cmd = CMD_UNUSED;
                else if (r < remove_pct)
                    cmd = CMD_REMOVE;
                else if ($urandom_range(0, 99) < 55)
                    cmd = CMD_PRIO;
                else
                    cmd = CMD_APPEND;
                push_request(cmd, pick_value(cur_threshold));
            end
        end
        calm = 1'b0;

        settle();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
